// ===== hw/rtl/odcs_pkg.sv =====
`default_nettype none

package odcs_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int CTR_W      = 16;
	localparam int RAD_W      = 14;
	localparam int THR_W      = 5;
	localparam int COLOR_W    = 8;
	localparam int PIX_W      = 13;
	localparam int BAYER_W    = 4;

	localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_RADIUS    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_COLOR     = 3'd4;

	localparam logic [THR_W-1:0] THRESHOLD_RST = 5'd8;

	localparam logic [1:0] DITHER_MASK = 2'd3;

	typedef logic [BAYER_W-1:0] bayer_t;

	// standard 4x4 Bayer matrix, row then column
	function automatic bayer_t bayer_level(input logic [1:0] row, input logic [1:0] col);
		bayer_t lvl;
		lvl = 4'd0;
		case ({row, col})
			4'b00_00: lvl = 4'd0;
			4'b00_01: lvl = 4'd8;
			4'b00_10: lvl = 4'd2;
			4'b00_11: lvl = 4'd10;
			4'b01_00: lvl = 4'd12;
			4'b01_01: lvl = 4'd4;
			4'b01_10: lvl = 4'd14;
			4'b01_11: lvl = 4'd6;
			4'b10_00: lvl = 4'd3;
			4'b10_01: lvl = 4'd11;
			4'b10_10: lvl = 4'd1;
			4'b10_11: lvl = 4'd9;
			4'b11_00: lvl = 4'd15;
			4'b11_01: lvl = 4'd7;
			4'b11_10: lvl = 4'd13;
			4'b11_11: lvl = 4'd5;
			default: lvl = 4'd0;
		endcase
		return lvl;
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/ordered_dither_circle_scan.sv =====
// Channel  Direction  Handshake             Payload
// in       sink       in_valid / in_stall   restart
// out      source     out_valid / out_stall pixel_x, pixel_y, paint, paint_color, last
// cfg      sink       cfg_we                cfg_index, cfg_data
//
// One transaction per clock sustained while the output is not stalled; each result passes
// through three register stages: scan step, two squarings, then the sum and radius compare.
// Reset clears the scan position and the pipeline valids and restores the register defaults.
// A stalled output holds; the two inner stages keep filling, so in_stall rises
// only when all three stages are occupied behind a stalled output.
`default_nettype none

module ordered_dither_circle_scan #(
	parameter int SUBPIXEL_SHIFT = 4
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  cfg_we,
	input  wire logic [odcs_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  wire logic [odcs_pkg::CFG_DATA_W-1:0]       cfg_data,
	input  wire logic                                  in_valid,
	output logic                                       in_stall,
	input  wire logic                                  restart,
	output logic                                       out_valid,
	input  wire logic                                  out_stall,
	output logic signed [odcs_pkg::PIX_W-1:0]          pixel_x,
	output logic signed [odcs_pkg::PIX_W-1:0]          pixel_y,
	output logic                                       paint,
	output logic [odcs_pkg::COLOR_W-1:0]               paint_color,
	output logic                                       last
);

	localparam int BW = odcs_pkg::CTR_W + 2;
	localparam int CW = BW - SUBPIXEL_SHIFT;
	localparam int DW = BW + 2;
	localparam int SW = 2 * DW;
	localparam int RSQ_W = 2 * odcs_pkg::RAD_W;
	localparam logic [BW-1:0] FRAC_MASK = BW'((1 << SUBPIXEL_SHIFT) - 1);
	localparam logic [DW-1:0] HALF = DW'(1) << (SUBPIXEL_SHIFT - 1);

	logic signed [odcs_pkg::CTR_W-1:0] cx_q, cy_q;
	logic [odcs_pkg::RAD_W-1:0]        rad_q;
	logic [odcs_pkg::THR_W-1:0]        thr_q;
	logic [odcs_pkg::COLOR_W-1:0]      color_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cx_q    <= '0;
			cy_q    <= '0;
			rad_q   <= '0;
			thr_q   <= odcs_pkg::THRESHOLD_RST;
			color_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				odcs_pkg::CFG_CENTER_X:  cx_q    <= cfg_data;
				odcs_pkg::CFG_CENTER_Y:  cy_q    <= cfg_data;
				odcs_pkg::CFG_RADIUS:    rad_q   <= cfg_data[odcs_pkg::RAD_W-1:0];
				odcs_pkg::CFG_THRESHOLD: thr_q   <= cfg_data[odcs_pkg::THR_W-1:0];
				odcs_pkg::CFG_COLOR:     color_q <= cfg_data[odcs_pkg::COLOR_W-1:0];
				default: ;
			endcase
		end
	end

	// bounding box
	logic signed [BW-1:0] cx_b, cy_b, rad_b;
	logic signed [BW-1:0] lo_x_w, hi_x_w, lo_y_w, hi_y_w;
	logic signed [BW-1:0] lo_x_sh, hi_x_sh, lo_y_sh, hi_y_sh;
	logic signed [CW-1:0] min_x, max_x, min_y, max_y;

	assign cx_b   = {{(BW-odcs_pkg::CTR_W){cx_q[odcs_pkg::CTR_W-1]}}, cx_q};
	assign cy_b   = {{(BW-odcs_pkg::CTR_W){cy_q[odcs_pkg::CTR_W-1]}}, cy_q};
	assign rad_b  = {{(BW-odcs_pkg::RAD_W){1'b0}}, rad_q};
	assign lo_x_w = cx_b - rad_b;
	assign hi_x_w = cx_b + rad_b + FRAC_MASK;
	assign lo_y_w = cy_b - rad_b;
	assign hi_y_w = cy_b + rad_b + FRAC_MASK;
	assign lo_x_sh = lo_x_w >>> SUBPIXEL_SHIFT;
	assign hi_x_sh = hi_x_w >>> SUBPIXEL_SHIFT;
	assign lo_y_sh = lo_y_w >>> SUBPIXEL_SHIFT;
	assign hi_y_sh = hi_y_w >>> SUBPIXEL_SHIFT;
	assign min_x = lo_x_sh[CW-1:0];
	assign max_x = hi_x_sh[CW-1:0];
	assign min_y = lo_y_sh[CW-1:0];
	assign max_y = hi_y_sh[CW-1:0];

	// pipeline flow
	logic v_s1, v_s2;
	logic adv_s1, adv_s2, take_in;

	assign adv_s2  = v_s2 && (!out_valid || !out_stall);
	assign adv_s1  = v_s1 && (!v_s2 || adv_s2);
	assign in_stall = v_s1 && !adv_s1;
	assign take_in = in_valid && !in_stall;

	// scan position
	logic signed [CW-1:0] col_q, row_q;
	logic                 started_q;
	logic signed [CW-1:0] col_nxt, row_nxt;
	logic                 wrap;

	assign wrap = restart || !started_q || (row_q > max_y) ||
		((row_q == max_y) && (col_q >= max_x));

	always_comb begin
		col_nxt = col_q + CW'(1);
		row_nxt = row_q;
		if (wrap) begin
			col_nxt = min_x;
			row_nxt = min_y;
		end else if (col_q >= max_x) begin
			col_nxt = min_x;
			row_nxt = row_q + CW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q     <= '0;
			row_q     <= '0;
			started_q <= 1'b0;
		end else if (take_in) begin
			col_q     <= col_nxt;
			row_q     <= row_nxt;
			started_q <= 1'b1;
		end
	end

	// stage 1: position
	logic signed [CW-1:0] col_s1, row_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (take_in || adv_s1) begin
			v_s1 <= take_in;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			col_s1 <= col_nxt;
			row_s1 <= row_nxt;
		end
	end

	logic signed [DW-1:0] col_d, row_d, cx_d, cy_d, dx, dy;
	logic signed [SW-1:0] sqx, sqy;
	logic                 pass_w, last_w;

	assign col_d = {{(DW-CW){col_s1[CW-1]}}, col_s1};
	assign row_d = {{(DW-CW){row_s1[CW-1]}}, row_s1};
	assign cx_d  = {{(DW-odcs_pkg::CTR_W){cx_q[odcs_pkg::CTR_W-1]}}, cx_q};
	assign cy_d  = {{(DW-odcs_pkg::CTR_W){cy_q[odcs_pkg::CTR_W-1]}}, cy_q};
	assign dx    = (col_d <<< SUBPIXEL_SHIFT) + HALF - cx_d;
	assign dy    = (row_d <<< SUBPIXEL_SHIFT) + HALF - cy_d;
	assign sqx   = dx * dx;
	assign sqy   = dy * dy;
	assign pass_w = {1'b0, odcs_pkg::bayer_level(row_s1[1:0] & odcs_pkg::DITHER_MASK,
		col_s1[1:0] & odcs_pkg::DITHER_MASK)} < thr_q;
	assign last_w = (col_s1 == max_x) && (row_s1 == max_y);

	// stage 2: squares
	logic signed [CW-1:0] col_s2, row_s2;
	logic [SW-1:0]        sqx_s2, sqy_s2;
	logic [RSQ_W-1:0]     rsq_s2;
	logic                 pass_s2, last_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv_s1 || adv_s2) begin
			v_s2 <= adv_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			col_s2  <= col_s1;
			row_s2  <= row_s1;
			sqx_s2  <= sqx;
			sqy_s2  <= sqy;
			rsq_s2  <= rad_q * rad_q;
			pass_s2 <= pass_w;
			last_s2 <= last_w;
		end
	end

	logic [SW:0]  dist_sq;
	logic         in_circle, paint_w;
	logic [31:0]  col_ext, row_ext;

	assign dist_sq = {1'b0, sqx_s2} + {1'b0, sqy_s2};
	assign in_circle = dist_sq <= {{(SW+1-RSQ_W){1'b0}}, rsq_s2};
	assign paint_w = in_circle && pass_s2;
	assign col_ext = {{(32-CW){col_s2[CW-1]}}, col_s2};
	assign row_ext = {{(32-CW){row_s2[CW-1]}}, row_s2};

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv_s2 || !out_stall) begin
			out_valid <= adv_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			pixel_x     <= col_ext[odcs_pkg::PIX_W-1:0];
			pixel_y     <= row_ext[odcs_pkg::PIX_W-1:0];
			paint       <= paint_w;
			paint_color <= paint_w ? color_q : '0;
			last        <= last_s2;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/odcs_checker.sv =====
`default_nettype none

module odcs_checker (
	input wire logic                                 clk,
	input wire logic                                 arst_n,
	input wire logic                                 in_stall,
	input wire logic                                 out_valid,
	input wire logic                                 out_stall,
	input wire logic signed [odcs_pkg::PIX_W-1:0]    pixel_x,
	input wire logic signed [odcs_pkg::PIX_W-1:0]    pixel_y,
	input wire logic                                 paint,
	input wire logic [odcs_pkg::COLOR_W-1:0]         paint_color,
	input wire logic                                 last
);

	// hold a stalled result
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
	else $error("out_valid dropped under stall");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(pixel_x) && $stable(pixel_y) &&
			$stable(paint) && $stable(paint_color) && $stable(last))
	else $error("output payload changed under stall");

	// input backpressure only when the result register is blocked
	assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
	else $error("in_stall without a blocked output");

	// unpainted pixels carry no colour
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !paint |-> paint_color == '0)
	else $error("paint_color set on an unpainted pixel");

endmodule

bind ordered_dither_circle_scan odcs_checker u_odcs_checker (.*);

`default_nettype wire

// ===== bench/ordered_dither_circle_scan_test.sv =====
`default_nettype none

module ordered_dither_circle_scan_test;

	localparam int SUBPIXEL_SHIFT = 4;
	localparam int SETTLE_CYCLES  = 8;
	localparam int RANDOM_PHASES  = 25;

	typedef struct {
		logic signed [odcs_pkg::PIX_W-1:0] x;
		logic signed [odcs_pkg::PIX_W-1:0] y;
		logic                              paint;
		logic [odcs_pkg::COLOR_W-1:0]      color;
		logic                              last;
	} pixel_t;

	logic                                clk       = 1'b0;
	logic                                arst_n    = 1'b0;
	logic                                cfg_we    = 1'b0;
	logic [odcs_pkg::CFG_IDX_W-1:0]      cfg_index = '0;
	logic [odcs_pkg::CFG_DATA_W-1:0]     cfg_data  = '0;
	logic                                in_valid  = 1'b0;
	logic                                restart   = 1'b0;
	logic                                out_stall = 1'b0;
	wire logic                           in_stall;
	wire logic                           out_valid;
	wire logic signed [odcs_pkg::PIX_W-1:0] pixel_x;
	wire logic signed [odcs_pkg::PIX_W-1:0] pixel_y;
	wire logic                           paint;
	wire logic [odcs_pkg::COLOR_W-1:0]   paint_color;
	wire logic                           last;

	logic signed [odcs_pkg::CTR_W-1:0] circle_cx  = '0;
	logic signed [odcs_pkg::CTR_W-1:0] circle_cy  = '0;
	logic [odcs_pkg::RAD_W-1:0]        circle_r   = '0;
	logic [odcs_pkg::THR_W-1:0]        dither_thr = odcs_pkg::THRESHOLD_RST;
	logic [odcs_pkg::COLOR_W-1:0]      fill_code  = '0;

	longint walk_col    = 0;
	longint walk_row    = 0;
	bit     walk_active = 1'b0;

	logic [3:0] dither_level [4][4] = '{
		'{4'd0,  4'd8,  4'd2,  4'd10},
		'{4'd12, 4'd4,  4'd14, 4'd6},
		'{4'd3,  4'd11, 4'd1,  4'd9},
		'{4'd15, 4'd7,  4'd13, 4'd5}
	};

	logic   restart_queue[$];
	pixel_t expected_pixels[$];
	int     send_idle_pct = 0;
	int     stall_pct     = 0;
	int     errors        = 0;

	ordered_dither_circle_scan #(
		.SUBPIXEL_SHIFT(SUBPIXEL_SHIFT)
	) u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.restart    (restart),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.pixel_x    (pixel_x),
		.pixel_y    (pixel_y),
		.paint      (paint),
		.paint_color(paint_color),
		.last       (last)
	);

	always #2 clk = ~clk;

	function automatic void box_span(input longint c, output longint lo, output longint hi);
		lo = (c - longint'(circle_r)) >>> SUBPIXEL_SHIFT;
		hi = (c + longint'(circle_r) + (longint'(1) << SUBPIXEL_SHIFT) - 1) >>> SUBPIXEL_SHIFT;
	endfunction

	function automatic pixel_t next_scan_pixel(input logic rst);
		longint min_x, max_x, min_y, max_y;
		longint half, dx, dy, r_sq;
		logic   in_circle, pass;
		pixel_t px;
		box_span(longint'(circle_cx), min_x, max_x);
		box_span(longint'(circle_cy), min_y, max_y);
		if (rst || !walk_active || walk_row > max_y ||
				(walk_row == max_y && walk_col >= max_x)) begin
			walk_col = min_x;
			walk_row = min_y;
		end else if (walk_col >= max_x) begin
			walk_col = min_x;
			walk_row = walk_row + 1;
		end else begin
			walk_col = walk_col + 1;
		end
		walk_active = 1'b1;
		half = longint'(1) << (SUBPIXEL_SHIFT - 1);
		dx = (walk_col << SUBPIXEL_SHIFT) + half - longint'(circle_cx);
		dy = (walk_row << SUBPIXEL_SHIFT) + half - longint'(circle_cy);
		r_sq = longint'(circle_r) * longint'(circle_r);
		in_circle = (dx * dx + dy * dy <= r_sq);
		pass = dither_level[int'(walk_row & 3)][int'(walk_col & 3)] < dither_thr;
		px.x = odcs_pkg::PIX_W'(walk_col);
		px.y = odcs_pkg::PIX_W'(walk_row);
		px.paint = in_circle && pass;
		px.color = (in_circle && pass) ? fill_code : '0;
		px.last = (walk_col == max_x && walk_row == max_y);
		return px;
	endfunction

	task automatic check_field(input string name, input logic signed [15:0] want_v,
			input logic signed [15:0] got_v);
		if (want_v !== got_v) begin
			$error("%s mismatch: expected %0d, actual %0d", name, want_v, got_v);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			restart <= 1'b0;
		end else begin
			if (in_valid && !in_stall)
				expected_pixels.push_back(next_scan_pixel(restart));
			if (!in_valid || !in_stall) begin
				if (restart_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					in_valid <= 1'b1;
					restart <= restart_queue.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin : monitor
		pixel_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_pixels.size() == 0) begin
					$error("unexpected transaction: pixel_x %0d pixel_y %0d", pixel_x, pixel_y);
					errors++;
				end else begin
					want = expected_pixels.pop_front();
					check_field("pixel_x", want.x, pixel_x);
					check_field("pixel_y", want.y, pixel_y);
					check_field("paint", {15'd0, want.paint}, {15'd0, paint});
					check_field("paint_color", {8'd0, want.color}, {8'd0, paint_color});
					check_field("last", {15'd0, want.last}, {15'd0, last});
				end
			end
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	task automatic write_reg(input logic [odcs_pkg::CFG_IDX_W-1:0] idx,
			input logic [odcs_pkg::CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		case (idx)
			odcs_pkg::CFG_CENTER_X:  circle_cx = data;
			odcs_pkg::CFG_CENTER_Y:  circle_cy = data;
			odcs_pkg::CFG_RADIUS:    circle_r = data[odcs_pkg::RAD_W-1:0];
			odcs_pkg::CFG_THRESHOLD: dither_thr = data[odcs_pkg::THR_W-1:0];
			odcs_pkg::CFG_COLOR:     fill_code = data[odcs_pkg::COLOR_W-1:0];
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic wait_idle();
		while (restart_queue.size() != 0 || in_valid || expected_pixels.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_idling(input int mode);
		case (mode)
			1: begin
				send_idle_pct <= 81;
				stall_pct <= 0;
			end
			2: begin
				send_idle_pct <= 0;
				stall_pct <= 81;
			end
			3: begin
				send_idle_pct <= 35;
				stall_pct <= 35;
			end
			default: begin
				send_idle_pct <= 0;
				stall_pct <= 0;
			end
		endcase
	endtask

	task automatic queue_steps(input int count, input int restart_pct);
		repeat (count) restart_queue.push_back($urandom_range(99) < restart_pct);
	endtask

	task automatic pick_threshold();
		if ($urandom_range(3) == 0)
			write_reg(odcs_pkg::CFG_THRESHOLD, odcs_pkg::CFG_DATA_W'($urandom_range(31)));
		else
			write_reg(odcs_pkg::CFG_THRESHOLD, odcs_pkg::CFG_DATA_W'($urandom_range(16)));
	endtask

	initial begin
		int kind;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		restart_queue = '{1'b0, 1'b0, 1'b0, 1'b1, 1'b0};
		wait_idle();

		write_reg(odcs_pkg::CFG_CENTER_X, 16'h8000);
		write_reg(odcs_pkg::CFG_CENTER_Y, 16'h7fff);
		write_reg(odcs_pkg::CFG_RADIUS, 16'h3fff);
		write_reg(odcs_pkg::CFG_THRESHOLD, 16'd31);
		write_reg(odcs_pkg::CFG_COLOR, 16'h00ff);
		restart_queue = '{1'b1, 1'b0, 1'b0, 1'b0};
		wait_idle();

		write_reg(odcs_pkg::CFG_CENTER_X, 16'h7fff);
		write_reg(odcs_pkg::CFG_CENTER_Y, 16'h8000);
		write_reg(odcs_pkg::CFG_RADIUS, 16'd0);
		write_reg(odcs_pkg::CFG_THRESHOLD, 16'd0);
		write_reg(odcs_pkg::CFG_COLOR, 16'h005a);
		restart_queue = '{1'b0, 1'b0, 1'b1, 1'b0};
		wait_idle();

		write_reg(odcs_pkg::CFG_CENTER_X, 16'd8);
		write_reg(odcs_pkg::CFG_CENTER_Y, 16'd8);
		write_reg(odcs_pkg::CFG_RADIUS, 16'd40);
		write_reg(odcs_pkg::CFG_THRESHOLD, 16'd16);
		write_reg(odcs_pkg::CFG_COLOR, 16'h00a5);
		restart_queue = '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0};
		wait_idle();

		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			set_idling(ph % 4);
			kind = $urandom_range(9);
			if (kind == 0) begin
				write_reg(odcs_pkg::CFG_CENTER_X, odcs_pkg::CFG_DATA_W'($urandom));
				write_reg(odcs_pkg::CFG_CENTER_Y, odcs_pkg::CFG_DATA_W'($urandom));
				write_reg(odcs_pkg::CFG_RADIUS, odcs_pkg::CFG_DATA_W'($urandom_range(16383)));
				pick_threshold();
				write_reg(odcs_pkg::CFG_COLOR, odcs_pkg::CFG_DATA_W'($urandom_range(255)));
			end else begin
				if (kind == 1)
					write_reg(odcs_pkg::CFG_CENTER_X, odcs_pkg::CFG_DATA_W'($urandom));
				else if ($urandom_range(1))
					write_reg(odcs_pkg::CFG_CENTER_X,
						circle_cx + 16'($urandom_range(128)) - 16'd64);
				if (kind == 1)
					write_reg(odcs_pkg::CFG_CENTER_Y, odcs_pkg::CFG_DATA_W'($urandom));
				else if ($urandom_range(1))
					write_reg(odcs_pkg::CFG_CENTER_Y,
						circle_cy + 16'($urandom_range(128)) - 16'd64);
				if ($urandom_range(1))
					write_reg(odcs_pkg::CFG_RADIUS, odcs_pkg::CFG_DATA_W'($urandom_range(120)));
				if ($urandom_range(2) == 0)
					pick_threshold();
				if ($urandom_range(1))
					write_reg(odcs_pkg::CFG_COLOR, odcs_pkg::CFG_DATA_W'($urandom_range(255)));
			end
			queue_steps($urandom_range(40, 110), ($urandom_range(3) == 0) ? 15 : 2);
			wait_idle();
		end

		if (errors == 0 && expected_pixels.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		#1000000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

`default_nettype wire
